// ===== design/linear_system_solver_macros.svh =====
// Assertion macros used by the port-level checker of the linear system solver.
`ifndef LINEAR_SYSTEM_SOLVER_MACROS_SVH
`define LINEAR_SYSTEM_SOLVER_MACROS_SVH

// Property that must hold in the same cycle as its condition.
`define LSS_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Property that must hold in the cycle after its condition.
`define LSS_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== design/lss_pkg.sv =====
// Shared types and constants of the linear system solver.
package lss_pkg;
	localparam int DATA_W    = 32;
	localparam int FRAC_BITS = 16;
	localparam int SIZE_W    = 4;
	localparam int POS_W     = 7;
	localparam logic [POS_W-1:0] POS_TOP = '1;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

	typedef logic signed [DATA_W-1:0] word_t;

	typedef struct packed {
		logic  start;
		word_t num;
		word_t den;
	} div_req_t;

	typedef struct packed {
		logic  done;
		logic  zero_div;
		word_t quot;
	} div_rsp_t;
endpackage

// ===== design/lss_ifs.sv =====
// Channel interfaces of the linear system solver: matrix input, solution output, setup.
interface lss_in_if import lss_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t coefficient;
	logic  final_element;

	modport source (output valid, output coefficient, output final_element, input ready);
	modport sink (input valid, input coefficient, input final_element, output ready);
endinterface

interface lss_out_if import lss_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t unknown_value;
	logic  last_unknown;
	logic  zero_divisor;

	modport source (output valid, output unknown_value, output last_unknown,
		output zero_divisor, input ready);
	modport sink (input valid, input unknown_value, input last_unknown,
		input zero_divisor, output ready);
endinterface

interface lss_cfg_if import lss_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [SIZE_W-1:0] size_in_use;

	modport source (output valid, output size_in_use, input ready);
	modport sink (input valid, input size_in_use, output ready);
endinterface

// ===== design/lss_div.sv =====
// Iterative restoring divider for saturated Q16.16 quotients, one bit per cycle.
module lss_div import lss_pkg::*; #(
	parameter int WORD_BITS = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	localparam int EB = (WORD_BITS > DATA_W) ? DATA_W : WORD_BITS;
	localparam int QW = DATA_W + FRAC_BITS;
	localparam int CW = $clog2(QW);
	localparam logic [QW-1:0] QLIM = QW'(1) << (EB - 1);
	localparam word_t WMAX = DATA_W'((64'sd1 <<< (EB - 1)) - 64'sd1);
	localparam word_t WMIN = -WMAX - DATA_W'(1);

	logic              busy_q;
	logic              done_q;
	logic              dz_q;
	logic              neg_q;
	logic [CW-1:0]     cnt_q;
	logic [QW-1:0]     dvd_q;
	logic [DATA_W-1:0] dvs_q;
	logic [DATA_W-1:0] rem_q;
	word_t             quot_q;

	logic [DATA_W:0]   shifted;
	logic              ge;
	logic [DATA_W-1:0] rem_next;
	logic [QW-1:0]     dvd_next;
	logic [DATA_W-1:0] num_mag;
	logic [DATA_W-1:0] den_mag;
	word_t             final_q;

	always_comb begin
		num_mag  = req.num[DATA_W-1] ? DATA_W'(-req.num) : DATA_W'(req.num);
		den_mag  = req.den[DATA_W-1] ? DATA_W'(-req.den) : DATA_W'(req.den);
		shifted  = {rem_q, dvd_q[QW-1]};
		ge       = shifted >= {1'b0, dvs_q};
		rem_next = ge ? DATA_W'(shifted - {1'b0, dvs_q}) : shifted[DATA_W-1:0];
		dvd_next = {dvd_q[QW-2:0], ge};
		if (neg_q) begin
			final_q = (dvd_next > QLIM) ? WMIN : DATA_W'(-dvd_next);
		end else begin
			final_q = (dvd_next > QLIM - QW'(1)) ? WMAX : DATA_W'(dvd_next);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			dz_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				neg_q <= req.num[DATA_W-1] ^ req.den[DATA_W-1];
				if (req.den == '0) begin
					dz_q   <= 1'b1;
					done_q <= 1'b1;
					busy_q <= 1'b0;
					if (req.num > 0) quot_q <= WMAX;
					else if (req.num < 0) quot_q <= WMIN;
					else quot_q <= '0;
				end else begin
					dz_q   <= 1'b0;
					busy_q <= 1'b1;
					dvd_q  <= {num_mag, {FRAC_BITS{1'b0}}};
					dvs_q  <= den_mag;
					rem_q  <= '0;
					cnt_q  <= CW'(QW - 1);
				end
			end else if (busy_q) begin
				rem_q <= rem_next;
				dvd_q <= dvd_next;
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					quot_q <= final_q;
				end
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.zero_div = dz_q;
	assign rsp.quot     = quot_q;
endmodule

// ===== design/lss_engine.sv =====
// Matrix memory, shared multiplier and sequencer for elimination and back substitution.
module lss_engine import lss_pkg::*; #(
	parameter int MAX_UNKNOWNS = 8,
	parameter int WORD_BITS    = 32,
	parameter int NW           = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [NW-1:0] n,
	lss_in_if.sink        matrix,
	lss_out_if.source     solution
);
	localparam int EB    = (WORD_BITS > DATA_W) ? DATA_W : WORD_BITS;
	localparam int SH    = DATA_W - EB;
	localparam int DEPTH = MAX_UNKNOWNS * (MAX_UNKNOWNS + 1);
	localparam int AW    = $clog2(DEPTH);
	localparam int RW    = (MAX_UNKNOWNS > 1) ? $clog2(MAX_UNKNOWNS) : 1;
	localparam logic signed [64:0] WMAX65 = (65'sd1 <<< (EB - 1)) - 65'sd1;
	localparam logic signed [64:0] WMIN65 = -WMAX65 - 65'sd1;

	typedef enum logic [4:0] {
		S_IDLE, S_PIV_RD, S_PIV_CMP, S_SW_RD, S_SW_WA, S_SW_WB, S_DIV_RD, S_DIV_GO,
		S_DIV_WAIT, S_RED_RD, S_RED_MUL, S_RED_WR, S_BS_RD, S_BS_INIT, S_BS_LOOP,
		S_BS_MUL, S_BS_ACC, S_BS_GO, S_BS_DIV, S_EMIT
	} state_t;

	state_t            state_q;
	logic [NW-1:0]     i_q;
	logic [NW-1:0]     j_q;
	logic [NW-1:0]     k_q;
	logic [POS_W-1:0]  lp_q;
	logic              err_q;
	word_t             ratio_q;
	word_t             s_q;
	word_t             diag_q;
	word_t             x_q [MAX_UNKNOWNS];
	logic signed [63:0] prod_s1;
	logic              ov_q;
	word_t             oval_q;
	logic              olast_q;
	logic              ozd_q;

	word_t             mem [DEPTH];
	word_t             rd0_q;
	word_t             rd1_q;

	logic [NW:0]       cols;
	logic              rd_en;
	logic [AW-1:0]     ra0;
	logic [AW-1:0]     ra1;
	logic              we;
	logic [AW-1:0]     wa;
	word_t             wd;
	word_t             sx;
	word_t             mterm;
	word_t             diff;
	word_t             acc;
	word_t             mul_b;
	word_t             x_rd;
	logic [RW-1:0]     xi;
	logic              in_fire;
	logic              emit_load;
	div_req_t          dreq;
	div_rsp_t          drsp;

	function automatic word_t sat(input logic signed [64:0] v);
		if (v > WMAX65) return DATA_W'(WMAX65);
		if (v < WMIN65) return DATA_W'(WMIN65);
		return v[DATA_W-1:0];
	endfunction

	function automatic logic [AW-1:0] idx(input logic [NW-1:0] row,
		input logic [NW-1:0] col, input logic [NW:0] nc);
		return AW'(int'(row) * int'(nc) + int'(col));
	endfunction

	lss_div #(.WORD_BITS(WORD_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	always_comb begin
		cols      = {1'b0, n} + (NW+1)'(1);
		in_fire   = matrix.valid && matrix.ready;
		emit_load = (state_q == S_EMIT) && (!ov_q || solution.ready);
		sx        = (matrix.coefficient <<< SH) >>> SH;
		mterm     = sat(65'(prod_s1 >>> FRAC_BITS));
		diff      = sat(65'(rd1_q) - 65'(mterm));
		acc       = sat(65'(s_q) - 65'(mterm));
		xi        = (state_q == S_EMIT) ? k_q[RW-1:0] : j_q[RW-1:0];
		x_rd      = x_q[xi];
		mul_b     = (state_q == S_BS_MUL) ? x_rd : ratio_q;

		dreq.start = (state_q == S_DIV_GO) || (state_q == S_BS_GO);
		dreq.num   = (state_q == S_DIV_GO) ? rd0_q : s_q;
		dreq.den   = (state_q == S_DIV_GO) ? rd1_q : diag_q;

		rd_en = 1'b0;
		ra0   = idx(i_q, k_q, cols);
		ra1   = idx(j_q, k_q, cols);
		unique case (state_q)
			S_PIV_RD, S_DIV_RD: begin
				rd_en = 1'b1;
				ra0   = idx(j_q, i_q, cols);
				ra1   = idx(i_q, i_q, cols);
			end
			S_SW_RD, S_RED_RD: rd_en = 1'b1;
			S_BS_RD: begin
				rd_en = 1'b1;
				ra0   = idx(i_q, n, cols);
				ra1   = idx(i_q, i_q, cols);
			end
			S_BS_LOOP: begin
				rd_en = 1'b1;
				ra0   = idx(i_q, j_q, cols);
			end
			default: rd_en = 1'b0;
		endcase

		we = 1'b0;
		wa = AW'(lp_q);
		wd = sx;
		unique case (state_q)
			S_IDLE: we = in_fire && (int'(lp_q) < int'(n) * (int'(n) + 1));
			S_SW_WA: begin
				we = 1'b1;
				wa = idx(i_q, k_q, cols);
				wd = rd1_q;
			end
			S_SW_WB: begin
				we = 1'b1;
				wa = idx(j_q, k_q, cols);
				wd = rd0_q;
			end
			S_RED_WR: begin
				we = 1'b1;
				wa = idx(j_q, k_q, cols);
				wd = diff;
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (rd_en) begin
			rd0_q <= mem[ra0];
			rd1_q <= mem[ra1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			lp_q    <= '0;
			err_q   <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (emit_load) ov_q <= 1'b1;
			else if (solution.ready) ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (lp_q == '0) err_q <= 1'b0;
						if (matrix.final_element) begin
							lp_q <= '0;
							i_q  <= '0;
							j_q  <= NW'(1);
							if (int'(n) > 1) state_q <= S_PIV_RD;
							else state_q <= S_BS_RD;
						end else if (lp_q != POS_TOP) begin
							lp_q <= lp_q + POS_W'(1);
						end
					end
				end
				S_PIV_RD: state_q <= S_PIV_CMP;
				S_PIV_CMP: begin
					k_q <= '0;
					// Plain signed compare: a larger lower entry becomes the pivot row.
					if (rd0_q > rd1_q) state_q <= S_SW_RD;
					else state_q <= S_DIV_GO;
				end
				S_SW_RD: state_q <= S_SW_WA;
				S_SW_WA: state_q <= S_SW_WB;
				S_SW_WB: begin
					if (k_q == n) state_q <= S_DIV_RD;
					else begin
						k_q     <= k_q + NW'(1);
						state_q <= S_SW_RD;
					end
				end
				S_DIV_RD: state_q <= S_DIV_GO;
				S_DIV_GO: state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (drsp.done) begin
						ratio_q <= drsp.quot;
						if (drsp.zero_div) err_q <= 1'b1;
						k_q     <= '0;
						state_q <= S_RED_RD;
					end
				end
				S_RED_RD: state_q <= S_RED_MUL;
				S_RED_MUL: begin
					prod_s1 <= rd0_q * mul_b;
					state_q <= S_RED_WR;
				end
				S_RED_WR: begin
					if (k_q != n) begin
						k_q     <= k_q + NW'(1);
						state_q <= S_RED_RD;
					end else if (int'(j_q) + 1 < int'(n)) begin
						j_q     <= j_q + NW'(1);
						state_q <= S_PIV_RD;
					end else if (int'(i_q) + 2 < int'(n)) begin
						i_q     <= i_q + NW'(1);
						j_q     <= i_q + NW'(2);
						state_q <= S_PIV_RD;
					end else begin
						i_q     <= n - NW'(1);
						state_q <= S_BS_RD;
					end
				end
				S_BS_RD: state_q <= S_BS_INIT;
				S_BS_INIT: begin
					s_q     <= rd0_q;
					diag_q  <= rd1_q;
					j_q     <= i_q + NW'(1);
					state_q <= S_BS_LOOP;
				end
				S_BS_LOOP: begin
					if (j_q < n) state_q <= S_BS_MUL;
					else state_q <= S_BS_GO;
				end
				S_BS_MUL: begin
					prod_s1 <= rd0_q * mul_b;
					state_q <= S_BS_ACC;
				end
				S_BS_ACC: begin
					s_q     <= acc;
					j_q     <= j_q + NW'(1);
					state_q <= S_BS_LOOP;
				end
				S_BS_GO: state_q <= S_BS_DIV;
				S_BS_DIV: begin
					if (drsp.done) begin
						x_q[i_q[RW-1:0]] <= drsp.quot;
						if (drsp.zero_div) err_q <= 1'b1;
						if (i_q == '0) begin
							k_q     <= '0;
							state_q <= S_EMIT;
						end else begin
							i_q     <= i_q - NW'(1);
							state_q <= S_BS_RD;
						end
					end
				end
				S_EMIT: begin
					if (emit_load) begin
						oval_q  <= x_rd;
						olast_q <= (k_q == n - NW'(1));
						ozd_q   <= err_q;
						if (k_q == n - NW'(1)) state_q <= S_IDLE;
						else k_q <= k_q + NW'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign matrix.ready           = (state_q == S_IDLE);
	assign solution.valid         = ov_q;
	assign solution.unknown_value = oval_q;
	assign solution.last_unknown  = olast_q;
	assign solution.zero_divisor  = ozd_q;
endmodule

// ===== design/linear_system_solver.sv =====
// Loading accepts one element per cycle. The duration of the solve after the final element
// depends on row swaps and is set mostly by the one-bit-per-cycle divider (36 quotients
// for eight unknowns) and the read, multiply, write step per matrix entry. Results then
// leave one per cycle while the receiver is ready; no new element is taken until the last
// result is in the output register. Reset clears the sequencer, load position, error flag,
// output valid flag and size register (to eight), not the memory.
module linear_system_solver import lss_pkg::*; #(
	parameter int MAX_UNKNOWNS = 8,
	parameter int WORD_BITS    = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	lss_in_if.sink    matrix,
	lss_out_if.source solution,
	lss_cfg_if.sink   setup
);
	localparam int NW = $clog2(MAX_UNKNOWNS + 1);

	logic [SIZE_W-1:0] size_q;
	logic [NW-1:0]     n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (setup.valid && setup.ready) begin
			size_q <= setup.size_in_use;
		end
	end

	// Sizes outside one to the maximum are clamped.
	always_comb begin
		if (size_q == '0) n = NW'(1);
		else if (int'(size_q) > MAX_UNKNOWNS) n = NW'(MAX_UNKNOWNS);
		else n = NW'(size_q);
	end

	assign setup.ready = 1'b1;

	lss_engine #(
		.MAX_UNKNOWNS (MAX_UNKNOWNS),
		.WORD_BITS    (WORD_BITS),
		.NW           (NW)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.n        (n),
		.matrix   (matrix),
		.solution (solution)
	);
endmodule

// ===== design/lss_checker.sv =====
// Port-level checks of the linear system solver and their binding to the top level.
`include "linear_system_solver_macros.svh"

module lss_checker import lss_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  in_valid,
	input logic  in_ready,
	input logic  in_final,
	input logic  out_valid,
	input logic  out_ready,
	input word_t out_value,
	input logic  out_last
);
	`LSS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid,
		"stalled result transaction dropped")
	`LSS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_value),
		"stalled result value changed")
	`LSS_ASSERT_NEXT(a_busy_after_final, in_valid && in_ready && in_final, !in_ready,
		"input still taken after the final element")
	`LSS_ASSERT_NOW(a_busy_while_emit, out_valid && !out_last, !in_ready,
		"input taken while results of a run are still being sent")
endmodule

bind linear_system_solver lss_checker u_lss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (matrix.valid),
	.in_ready  (matrix.ready),
	.in_final  (matrix.final_element),
	.out_valid (solution.valid),
	.out_ready (solution.ready),
	.out_value (solution.unknown_value),
	.out_last  (solution.last_unknown)
);
